@@ rtl/prq_pkg.sv @@
// Package with the shared types and constants of the process ready queue.
`default_nettype none

package prq_pkg;

	// Operation codes of an input transaction.
	localparam logic [2:0] OP_PUSH   = 3'd0;
	localparam logic [2:0] OP_POP    = 3'd1;
	localparam logic [2:0] OP_REMOVE = 3'd2;
	localparam logic [2:0] OP_ROTATE = 3'd3;
	localparam logic [2:0] OP_FIND   = 3'd4;
	localparam logic [2:0] OP_TOP    = 3'd5;
	localparam logic [2:0] OP_EXISTS = 3'd6;

	// Status codes of a result transaction.
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;
	localparam logic [1:0] STAT_DUP  = 2'd3;

	// Level with a fixed quantum, and the quantum limits.
	localparam logic [6:0] LEVEL_SPECIAL   = 7'd99;
	localparam logic [7:0] QUANTUM_SPECIAL = 8'd99;
	localparam logic [7:0] QUANTUM_MAX     = 8'd255;

	// Highest priority that the top priority search considers.
	localparam logic [3:0] MAX_PRIORITY = 4'd10;

	// One stored process entry.
	typedef struct packed {
		logic [5:0]  slot;
		logic [15:0] pid;
		logic [3:0]  priority_val;
	} entry_t;

	// Input transaction payload.
	typedef struct packed {
		logic [2:0]  op;
		logic [5:0]  slot;
		logic [15:0] pid_value;
		logic [3:0]  priority_req;
	} in_item_t;

	// Result transaction payload.
	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  found_slot;
		logic [15:0] found_pid;
		logic [6:0]  assigned_level;
		logic [7:0]  time_quantum;
		logic [6:0]  entry_total;
	} out_item_t;

	// Per-cell control from the sequencer.
	typedef struct packed {
		logic shift;
		logic load_tail;
		logic load_new;
	} cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/prq_cell.sv @@
// One cell of the queue chain: holds a single entry and passes it to its left neighbor.
`default_nettype none

module prq_cell (
	input  wire                 clk,
	input  prq_pkg::cell_ctrl_t ctrl,
	input  prq_pkg::entry_t     right_entry,
	input  prq_pkg::entry_t     front_entry,
	input  prq_pkg::entry_t     new_entry,
	output prq_pkg::entry_t     entry
);
	import prq_pkg::*;

	entry_t entry_q;

	// A new entry lands here on append; otherwise the chain shifts toward the front,
	// and the tail cell takes the entry that leaves the front.
	always_ff @(posedge clk) begin
		if (ctrl.load_new) begin
			entry_q <= new_entry;
		end else if (ctrl.shift) begin
			entry_q <= ctrl.load_tail ? front_entry : right_entry;
		end
	end

	assign entry = entry_q;

endmodule

`default_nettype wire

@@ rtl/process_ready_queue_unit.sv @@
// Top level of the process ready queue: sequencer, configuration register and the cell chain.
// A transaction scans the held entries, and its result is registered in the finish state once
// the output is free; an empty queue or unused op code skips the scan. A rotate ends early
// at its match and a pop at the front entry. The next input is taken only after the result
// is registered; a scan turns the ring once, one entry through the front cell per cycle.
// Reset clears the entry count, the level register and the handshake state at once.
`default_nettype none

module process_ready_queue_unit #(
	parameter int DEPTH = 64
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  prq_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output prq_pkg::out_item_t  out_data,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire  [6:0]          cfg_data
);
	import prq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   step_q;
	logic [6:0]      level_q;
	in_item_t        item_q;
	logic            hit_q;
	entry_t          rec_q;
	out_item_t       out_q;
	logic            out_valid_q;

	entry_t          node_entry [DEPTH];
	cell_ctrl_t      node_ctrl  [DEPTH];
	entry_t          front;
	entry_t          new_entry;

	logic            m_slot, m_pid, pri_ok;
	logic            take, drop, stop, last;
	logic            shift, recirc, append;
	logic            out_free, push_ok;
	logic [8:0]      quantum_sum;
	logic [7:0]      quantum;
	logic [CW-1:0]   count_after;
	logic [31:0]     count_wide;
	out_item_t       result;

	// Configuration register; writes are always taken.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (cfg_valid) begin
			level_q <= cfg_data;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Compare the entry at the front cell against the held transaction.
	assign front  = node_entry[0];
	assign m_slot = (front.slot == item_q.slot);
	assign m_pid  = (front.pid == item_q.pid_value);
	assign pri_ok = (front.priority_val <= MAX_PRIORITY)
		&& (!hit_q || (front.priority_val < rec_q.priority_val));

	// Scan decisions for this cycle.
	always_comb begin
		take = 1'b0;
		drop = 1'b0;
		stop = 1'b0;
		if (state_q == ST_SCAN) begin
			unique case (item_q.op) inside
				OP_PUSH, OP_EXISTS: begin
					take = m_slot && !hit_q;
				end
				OP_REMOVE: begin
					take = m_slot && !hit_q;
					drop = take;
				end
				OP_ROTATE: begin
					take = m_slot;
					stop = take;
				end
				OP_FIND: begin
					take = m_pid && !hit_q;
				end
				OP_TOP: begin
					take = pri_ok;
				end
				OP_POP: begin
					take = 1'b1;
					drop = 1'b1;
					stop = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign shift  = (state_q == ST_SCAN) && (!stop || drop);
	assign recirc = !drop;
	assign last   = stop || (step_q == ONE_C);

	// A push is stored when the finish state hands off its result, if it met no duplicate and had room.
	assign push_ok = (item_q.op == OP_PUSH) && !hit_q && (count_q < DEPTH_C);
	assign append  = (state_q == ST_FINISH) && out_free && push_ok;

	assign new_entry.slot         = item_q.slot;
	assign new_entry.pid          = item_q.pid_value;
	assign new_entry.priority_val = item_q.priority_req;

	// Cell chain; each cell decodes its own position against the count.
	for (genvar i = 0; i < DEPTH; i++) begin : g_node
		localparam logic [CW-1:0] IDX = CW'(i);
		entry_t right_entry;

		if (i == DEPTH - 1) begin : g_last
			assign right_entry = node_entry[i];
		end else begin : g_mid
			assign right_entry = node_entry[i + 1];
		end

		assign node_ctrl[i].shift     = shift;
		assign node_ctrl[i].load_tail = shift && recirc && (IDX == (count_q - ONE_C));
		assign node_ctrl[i].load_new  = append && (IDX == count_q);

		prq_cell u_cell (
			.clk         (clk),
			.ctrl        (node_ctrl[i]),
			.right_entry (right_entry),
			.front_entry (front),
			.new_entry   (new_entry),
			.entry       (node_entry[i])
		);
	end

	// Quantum of this level, saturated, with the special level fixed.
	assign quantum_sum = {1'b0, level_q, 1'b0} + 9'd2;
	always_comb begin
		if (level_q == LEVEL_SPECIAL) begin
			quantum = QUANTUM_SPECIAL;
		end else if (quantum_sum[8]) begin
			quantum = QUANTUM_MAX;
		end else begin
			quantum = quantum_sum[7:0];
		end
	end

	assign count_after = count_q + (append ? ONE_C : '0);
	assign count_wide  = 32'(count_after);

	// Result assembled in the finish cycle.
	always_comb begin
		result                = '0;
		result.status         = STAT_MISS;
		result.entry_total    = count_wide[6:0];
		if (item_q.op == OP_PUSH) begin
			result.assigned_level = level_q;
			result.time_quantum   = quantum;
			if (hit_q) begin
				result.status = STAT_DUP;
			end else if (count_q >= DEPTH_C) begin
				result.status = STAT_FULL;
			end else begin
				result.status = STAT_OK;
			end
		end else if (hit_q) begin
			result.status     = STAT_OK;
			result.found_slot = rec_q.slot;
			result.found_pid  = rec_q.pid;
		end
	end

	// Sequencer and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			step_q      <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result replaces one that leaves in the same cycle.
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						hit_q  <= 1'b0;
						step_q <= count_q;
						if ((count_q != '0) && (in_data.op <= OP_EXISTS)) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_SCAN: begin
					if (take) begin
						hit_q <= 1'b1;
					end
					if (drop) begin
						count_q <= count_q - ONE_C;
					end
					step_q <= step_q - ONE_C;
					if (last) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						count_q <= count_after;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: held transaction, recorded entry and the result.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			item_q <= in_data;
		end
		if (take) begin
			rec_q <= front;
		end
		if (state_q == ST_FINISH && out_free) begin
			out_q <= result;
		end
	end

endmodule

`default_nettype wire
